// File: rtl/ssf_pkg.sv
// ssf_pkg: beat types, register indexes, reset values and q16.16 helpers
// for the selective scan forward block. Depends on nothing.

package ssf_pkg;

  // fraction bits of the q16.16 format
  localparam int unsigned Q_FRAC = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT = 2'd1;

  // register reset values
  localparam logic [15:0] GROUP_SIZE_RESET = 16'd1023;
  localparam logic [4:0] STATE_COUNT_RESET = 5'd16;

  // input beat
  typedef struct packed {
    logic [3:0]         state_index;
    logic signed [31:0] x_in;
    logic signed [31:0] a_coef;
    logic signed [31:0] b_coef;
    logic signed [31:0] c_coef;
    logic signed [31:0] h_init;
    logic               seq_start;
  } ssf_in_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] h_new;
    logic [3:0]         h_index;
    logic               checkpoint;
    logic signed [31:0] sum_out;
    logic               sum_valid;
  } ssf_out_t;

  // sequencer strobes into the state update unit
  typedef struct packed {
    logic       rd_en;
    logic       mul_en;
    logic       wr_en;
    logic       start;
    logic [3:0] idx;
  } ssf_ctl_t;

  // clamp a 49-bit sum to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v[48:31] == {18{1'b0}} || v[48:31] == {18{1'b1}}) begin
      r = v[31:0];
    end else if (v[48]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  // floor of a 64-bit product shifted down by the fraction bits
  function automatic logic signed [47:0] floor_q16(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> Q_FRAC;
    return s[47:0];
  endfunction

endpackage

// File: rtl/selective_scan_forward.sv
// selective_scan_forward: top level with sequencer, step sum, group countdown
// and result register. Depends on ssf_pkg and ssf_recur.
//
// Each accepted beat updates one state element. Its result is loaded into the
// result register after the stages below; it waits in the last stage while a
// stalled result still holds that register. The five stages are: memory
// read, a*h_prev and b*x products, saturating add with write back, c*h
// product, then step sum and countdown into the result register. A new beat
// is taken once the previous result has reached the result register, so the
// block takes no new beat while one is in flight. A stalled result costs
// nothing while the next beat passes the earlier stages; past that, the stall
// holds the next input beat back. Beats whose index is not below the active
// state count are taken without leaving the idle state and give no result.
// The state memory needs no clearing after reset.

module selective_scan_forward #(
  parameter int STATE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ssf_pkg::ssf_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ssf_pkg::ssf_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_HNEW = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;
  localparam logic [8:0] DEPTH_CNT = 9'(STATE_DEPTH);

  logic [2:0]          state_r, state_nxt;
  logic [15:0]         group_size_r;
  logic [4:0]          state_count_r;
  ssf_pkg::ssf_in_t    item_r;
  logic                last_r;
  logic signed [63:0]  ch_r;
  logic signed [31:0]  sum_r, sum_nxt;
  logic [15:0]         cd_r, cd_nxt;
  logic                out_valid_r;
  ssf_pkg::ssf_out_t   out_data_r;

  ssf_pkg::ssf_ctl_t   ctl;
  logic signed [31:0]  h_cur;
  logic [8:0]          count_raw;
  logic [8:0]          count_eff;
  logic [8:0]          idx_ext;
  logic                accept;
  logic                in_range;
  logic                commit;
  logic                idx0;
  logic [15:0]         reload;
  logic [15:0]         cd_base;
  logic signed [31:0]  sum_base;
  logic signed [31:0]  sum_acc;
  logic                ckpt;

  // configuration writes, taken at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r  <= ssf_pkg::GROUP_SIZE_RESET;
      state_count_r <= ssf_pkg::STATE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ssf_pkg::REG_GROUP_SIZE:  group_size_r  <= cfg_data;
        ssf_pkg::REG_STATE_COUNT: state_count_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // active state count, clamped to one and to the memory depth
  assign count_raw = (state_count_r == 5'd0) ? 9'd1 : {4'd0, state_count_r};
  assign count_eff = (count_raw > DEPTH_CNT) ? DEPTH_CNT : count_raw;
  assign idx_ext   = {5'd0, in_data.state_index};
  assign in_range  = idx_ext < count_eff;

  // handshake
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign commit   = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && in_range) state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_HNEW;
      ST_HNEW: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_DONE;
      ST_DONE: if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      last_r <= (idx_ext == count_eff - 9'd1);
    end
  end

  // strobes into the update unit
  always_comb begin
    ctl.rd_en  = accept && in_range;
    ctl.mul_en = (state_r == ST_MUL1);
    ctl.wr_en  = (state_r == ST_HNEW);
    ctl.start  = item_r.seq_start;
    ctl.idx    = (state_r == ST_IDLE) ? in_data.state_index : item_r.state_index;
  end

  ssf_recur #(
    .STATE_DEPTH (STATE_DEPTH)
  ) u_recur (
    .clk    (clk),
    .ctl    (ctl),
    .x_in   (item_r.x_in),
    .a_coef (item_r.a_coef),
    .b_coef (item_r.b_coef),
    .h_init (item_r.h_init),
    .h_out  (h_cur)
  );

  // c*h product
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL2) begin
      ch_r <= item_r.c_coef * h_cur;
    end
  end

  // step sum and group countdown
  always_comb begin
    idx0     = (item_r.state_index == 4'd0);
    reload   = (group_size_r == 16'd0) ? 16'd1 : group_size_r;
    cd_base  = (idx0 && item_r.seq_start) ? reload : cd_r;
    sum_base = idx0 ? 32'sd0 : sum_r;
    sum_acc  = ssf_pkg::sat32(49'(sum_base) + 49'(ssf_pkg::floor_q16(ch_r)));
    ckpt     = (cd_base <= 16'd1);
    if (last_r) begin
      sum_nxt = 32'sd0;
      cd_nxt  = ckpt ? reload : cd_base - 16'd1;
    end else begin
      sum_nxt = sum_acc;
      cd_nxt  = cd_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= 32'sd0;
      cd_r  <= ssf_pkg::GROUP_SIZE_RESET;
    end else if (commit) begin
      sum_r <= sum_nxt;
      cd_r  <= cd_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r.h_new      <= h_cur;
      out_data_r.h_index    <= item_r.state_index;
      out_data_r.checkpoint <= ckpt;
      out_data_r.sum_out    <= last_r ? sum_acc : 32'sd0;
      out_data_r.sum_valid  <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/ssf_recur.sv
// ssf_recur: state memory and the h = a*h_prev + b*x update (read, two
// products, saturating add and write back). Depends on ssf_pkg.

module ssf_recur #(
  parameter int STATE_DEPTH = 16
) (
  input  logic                   clk,
  input  ssf_pkg::ssf_ctl_t      ctl,
  input  logic signed [31:0]     x_in,
  input  logic signed [31:0]     a_coef,
  input  logic signed [31:0]     b_coef,
  input  logic signed [31:0]     h_init,
  output logic signed [31:0]     h_out
);

  localparam int AW = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;

  logic signed [31:0] state_mem [STATE_DEPTH];
  logic signed [31:0] rdata_r;
  logic signed [63:0] prod_a_r;
  logic signed [63:0] prod_b_r;
  logic signed [31:0] h_r;
  logic [8:0]         idx_ext;
  logic [AW-1:0]      addr;
  logic signed [31:0] h_prev;
  logic signed [48:0] h_sum;
  logic signed [31:0] h_nxt;

  // element address
  assign idx_ext = {5'd0, ctl.idx};
  assign addr    = idx_ext[AW-1:0];

  // previous state: start value or stored element
  assign h_prev = ctl.start ? h_init : rdata_r;

  // sum of floored products, saturated
  assign h_sum = 49'(ssf_pkg::floor_q16(prod_a_r)) + 49'(ssf_pkg::floor_q16(prod_b_r));
  assign h_nxt = ssf_pkg::sat32(h_sum);

  // state memory, one read and one write port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= state_mem[addr];
    end
    if (ctl.wr_en) begin
      state_mem[addr] <= h_nxt;
    end
  end

  // product and result registers
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_a_r <= a_coef * h_prev;
      prod_b_r <= b_coef * x_in;
    end
    if (ctl.wr_en) begin
      h_r <= h_nxt;
    end
  end

  assign h_out = h_r;

endmodule

// File: rtl/ssf_checker.sv
// ssf_checker: port-level checks on selective_scan_forward, bound to the top.
// Depends on ssf_pkg.

module ssf_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input ssf_pkg::ssf_out_t     out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // sum is zero unless it closes a step
  a_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.sum_valid |-> out_data.sum_out == 32'sd0)
    else $error("nonzero sum without sum_valid");

  // a fresh result never shows the cycle after an input beat
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too soon after input beat");

endmodule

bind selective_scan_forward ssf_checker u_ssf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
